[rtl/tvte_pkg.sv]
`timescale 1ns / 1ps

package tvte_pkg;

	typedef enum logic [2:0] {
		OP_INT    = 3'd0,
		OP_REAL32 = 3'd1,
		OP_REAL64 = 3'd2,
		OP_BINARY = 3'd3,
		OP_STRING = 3'd4
	} tvte_op_t;

	localparam int unsigned NUM_CHARS = 17;
	localparam int unsigned POS_W     = $clog2(NUM_CHARS);

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_CHARS - 1);

	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_FOUR   = 8'h34;
	localparam logic [7:0] CH_EIGHT  = 8'h38;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;
	localparam logic [7:0] CH_LOWER_T = 8'h74;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// Text of one request: characters pos..16 of chars, preceded by chars[0] when pre is set.
	typedef struct packed {
		logic                        act;
		logic                        pre;
		logic [POS_W-1:0]            pos;
		logic [NUM_CHARS-1:0][7:0]   chars;
	} tvte_text_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'd0, nib};
		end else begin
			c = CH_UPPER_A + {4'd0, nib} - 8'd10;
		end
		return c;
	endfunction

endpackage

[rtl/tvte_enc.sv]
`timescale 1ns / 1ps

module tvte_enc
	import tvte_pkg::*;
(
	input  logic [2:0]  operation,
	input  logic        is_signed,
	input  logic [63:0] value_bits,
	input  logic        swap,
	output tvte_text_t  text
);

	logic        int_neg;
	logic [63:0] mag;
	logic [3:0]  msd;
	logic        is64;
	logic        rneg;
	logic [63:0] abs_b;
	logic [63:0] max_b;
	logic [63:0] inf_b;
	logic [63:0] raw;
	logic [63:0] swapped;
	logic [63:0] w;
	logic [7:0]  wch;
	logic [7:0]  b;

	always_comb begin
		int_neg = is_signed & value_bits[63];
		mag = int_neg ? (~value_bits + 64'd1) : value_bits;
		msd = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (mag[4*i +: 4] != 4'd0) begin
				msd = 4'(i);
			end
		end
	end

	always_comb begin
		is64 = (operation == OP_REAL64);
		if (is64) begin
			raw   = value_bits;
			rneg  = value_bits[63];
			abs_b = {1'b0, value_bits[62:0]};
			max_b = 64'h7FEF_FFFF_FFFF_FFFF;
			inf_b = 64'h7FF0_0000_0000_0000;
			for (int i = 0; i < 8; i++) begin
				swapped[8*i +: 8] = value_bits[8*(7-i) +: 8];
			end
			wch = CH_EIGHT;
		end else begin
			raw   = {32'd0, value_bits[31:0]};
			rneg  = value_bits[31];
			abs_b = {33'd0, value_bits[30:0]};
			max_b = 64'h0000_0000_7F7F_FFFF;
			inf_b = 64'h0000_0000_7F80_0000;
			swapped = {32'd0, value_bits[7:0], value_bits[15:8],
				value_bits[23:16], value_bits[31:24]};
			wch = CH_FOUR;
		end
		w = swap ? swapped : raw;
		b = value_bits[7:0];
	end

	always_comb begin
		text     = '0;
		text.act = 1'b1;
		unique case (tvte_op_t'(operation))
			OP_INT: begin
				text.pre      = int_neg;
				text.chars[0] = CH_MINUS;
				for (int k = 0; k < 16; k++) begin
					text.chars[1+k] = hex_char(mag[4*(15-k) +: 4]);
				end
				text.pos = POS_LAST - {1'b0, msd};
			end
			OP_REAL32, OP_REAL64: begin
				if (abs_b == 64'd0) begin
					text.chars[14] = CH_Z;
					text.chars[15] = wch;
					text.chars[16] = CH_ZERO;
					text.pos = POS_W'(14);
				end else if (abs_b == max_b || abs_b == inf_b) begin
					text.chars[13] = CH_Z;
					text.chars[14] = wch;
					text.chars[15] = rneg ? CH_MINUS : CH_PLUS;
					text.chars[16] = (abs_b == max_b) ? CH_M : CH_I;
					text.pos = POS_W'(13);
				end else if (abs_b > inf_b) begin
					text.chars[14] = CH_Z;
					text.chars[15] = wch;
					text.chars[16] = CH_QUEST;
					text.pos = POS_W'(14);
				end else begin
					for (int k = 0; k < 16; k++) begin
						text.chars[1+k] = CH_G + {4'd0, w[4*(15-k) +: 4]};
					end
					text.pos = is64 ? POS_W'(1) : POS_W'(9);
				end
			end
			OP_BINARY: begin
				text.chars[15] = hex_char(b[7:4]);
				text.chars[16] = hex_char(b[3:0]);
				text.pos = POS_W'(15);
			end
			OP_STRING: begin
				text.chars[15] = CH_BSLASH;
				if (b == CH_BSLASH) begin
					text.chars[16] = CH_BSLASH;
					text.pos = POS_W'(15);
				end else if (b == CH_TAB) begin
					text.chars[16] = CH_LOWER_T;
					text.pos = POS_W'(15);
				end else if (b == CH_NL) begin
					text.chars[16] = CH_LOWER_N;
					text.pos = POS_W'(15);
				end else begin
					text.chars[16] = b;
					text.pos = POS_LAST;
				end
			end
			default: begin
				text.act = 1'b0;
			end
		endcase
	end

endmodule

[rtl/typed_value_text_encoder.sv]
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its text comes out one character
// per cycle on character, each marked by strobe, with last on the final one, and the
// receiver must take every character in the cycle it appears. A request yields 1 to 17
// characters; one request is held in the input register while the previous one drains,
// and the next request's text follows the previous one's last character without a gap.
// The first character of a request appears once the request has passed through the input
// register and then the output register, when the output is idle. Requests with an
// undefined operation give no characters but still pass through the input and output
// registers, so they leave a gap in the output.
module typed_value_text_encoder
	import tvte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic        is_signed,
	input  logic [63:0] value_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        strobe,
	output logic [7:0]  character,
	output logic        last
);

	logic        swap_q;
	logic        vld_s1;
	logic [2:0]  op_s1;
	logic        sgn_s1;
	logic [63:0] val_s1;
	tvte_text_t  enc;
	tvte_text_t  txt_s2;
	logic        take;
	logic        free;
	logic        done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			swap_q <= cfg_data;
		end
	end

	assign done = txt_s2.act && !txt_s2.pre && (txt_s2.pos == POS_LAST);
	assign free = !txt_s2.act || done;
	assign busy = vld_s1 && !free;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take || busy;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= operation;
			sgn_s1 <= is_signed;
			val_s1 <= value_bits;
		end
	end

	tvte_enc u_enc (
		.operation  (op_s1),
		.is_signed  (sgn_s1),
		.value_bits (val_s1),
		.swap       (swap_q),
		.text       (enc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_s2 <= '0;
		end else if (vld_s1 && free) begin
			txt_s2 <= enc;
		end else if (txt_s2.act) begin
			if (txt_s2.pre) begin
				txt_s2.pre <= 1'b0;
			end else if (done) begin
				txt_s2.act <= 1'b0;
			end else begin
				txt_s2.pos <= txt_s2.pos + POS_W'(1);
			end
		end
	end

	assign strobe    = txt_s2.act;
	assign character = txt_s2.pre ? txt_s2.chars[0] : txt_s2.chars[txt_s2.pos];
	assign last      = done;

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> vld_s1)
		else $error("Accepted request did not reach the input register.");

	a_text_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("Text of a request stopped before its last character.");

	a_busy_drains: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> vld_s1 && strobe)
		else $error("Busy while the output stage is not emitting.");

	a_prefix_first: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && txt_s2.pre |=> strobe && !txt_s2.pre)
		else $error("Sign prefix was not followed by digits.");

endmodule
